[rtl/core/mchw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mchw_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;
    localparam int TIME_W      = 32;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_FEED     = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    localparam logic [1:0] KIND_ANSWER    = 2'd0;
    localparam logic [1:0] KIND_FEED      = 2'd1;
    localparam logic [1:0] KIND_OFFLINE   = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE = 2'd3;

    localparam logic [1:0] CL_INIT    = 2'd0;
    localparam logic [1:0] CL_ONLINE  = 2'd1;
    localparam logic [1:0] CL_OFFLINE = 2'd2;

    localparam logic CFG_FAULT_HOOK = 1'b0;
    localparam logic CFG_HW_FEED    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk_start;
        logic walk_step;
        logic walk_hold;
        logic tick_done;
    } cmd_t;

    typedef struct packed {
        logic req_tick;
        logic out_free;
        logic count_zero;
        logic last_slot;
        logic need_report;
    } stat_t;

endpackage

`default_nettype wire

[rtl/core/mchw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mchw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/mchw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mchw_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mchw_pkg::stat_t stat,
    output mchw_pkg::cmd_t     cmd
);

    import mchw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.req_tick)
                begin
                    state_next = stat.count_zero ? ST_DONE : ST_WALK;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if ((!stat.need_report || stat.out_free) && stat.last_slot)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                if (stat.req_tick)
                begin
                    cmd.walk_start = 1'b1;
                end
                else
                begin
                    cmd.exec = stat.out_free;
                end
            end
            ST_WALK:
            begin
                if (stat.need_report && !stat.out_free)
                begin
                    cmd.walk_hold = 1'b1;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.tick_done = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/mchw_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module mchw_datapath #(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic          cfg_data,
    input  wire logic [1:0]    req_type,
    input  wire logic [3:0]    client_index,
    input  wire logic [31:0]   now_ms,
    input  wire logic [31:0]   expiry_ms,
    input  wire logic          is_fatal,
    input  wire logic          is_critical,
    input  wire mchw_pkg::cmd_t cmd,
    output mchw_pkg::stat_t    stat,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [1:0]         result_kind,
    output logic [3:0]         slot,
    output logic               accepted,
    output logic               fatal_hook,
    output logic               feed_hw_watchdog,
    output logic               last
);

    import mchw_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SEL_W  = (CNT_W > 4) ? CNT_W : 4;
    localparam int A_W    = TIME_W + 2;
    localparam int B_W    = TIME_W + 2;

    logic [1:0]        req_reg;
    logic [3:0]        idx_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] tmo_reg;
    logic              fat_reg;
    logic              crit_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] eval_idx_reg;
    logic              crit_ok_reg;
    logic              fault_hook_en_reg;
    logic              hw_feed_en_reg;

    logic              out_valid_reg;
    logic [1:0]        kind_reg;
    logic [3:0]        slot_reg;
    logic              acc_reg;
    logic              fatal_reg;
    logic              feed_reg;
    logic              last_reg;

    logic              a_we;
    logic [SLOT_W-1:0] a_waddr;
    logic [A_W-1:0]    a_wdata;
    logic [A_W-1:0]    a_rdata;
    logic              b_we;
    logic [SLOT_W-1:0] b_waddr;
    logic [B_W-1:0]    b_wdata;
    logic [B_W-1:0]    b_rdata;
    logic [SLOT_W-1:0] raddr;

    logic [TIME_W-1:0] a_tmo;
    logic              a_fat;
    logic              a_crit;
    logic [TIME_W-1:0] b_seen;
    logic [1:0]        b_state;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;
    logic              need_report;
    logic              online_after;

    logic              room;
    logic              feed_ok;
    logic [SEL_W-1:0]  count_wide;
    logic [SEL_W-1:0]  eval_wide;
    logic              out_free;
    logic              report_load;
    logic              load;

    logic [1:0]        kind_next;
    logic [3:0]        slot_next;
    logic              acc_next;
    logic              fatal_next;
    logic              feed_next;
    logic              last_next;

    mchw_ram #(
        .WIDTH (A_W),
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W)
    ) u_ram_cfg (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (raddr),
        .rdata (a_rdata)
    );

    mchw_ram #(
        .WIDTH (B_W),
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W)
    ) u_ram_live (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (raddr),
        .rdata (b_rdata)
    );

    assign a_tmo   = a_rdata[A_W-1:2];
    assign a_fat   = a_rdata[1];
    assign a_crit  = a_rdata[0];
    assign b_seen  = b_rdata[B_W-1:2];
    assign b_state = b_rdata[1:0];

    assign elapsed      = now_reg - b_seen;
    assign timed_out    = elapsed > a_tmo;
    assign need_report  = timed_out && (b_state != CL_OFFLINE);
    assign online_after = (b_state == CL_ONLINE) && !timed_out;

    assign room       = count_reg < CNT_W'(MAX_SLOTS);
    assign feed_ok    = SEL_W'(idx_reg) < SEL_W'(count_reg);
    assign count_wide = SEL_W'(count_reg);
    assign eval_wide  = SEL_W'(eval_idx_reg);

    assign out_free    = !out_valid_reg || out_ready;
    assign report_load = cmd.walk_step && need_report;
    assign load        = cmd.exec || report_load || cmd.tick_done;

    always_comb
    begin
        if (cmd.walk_step)
        begin
            raddr = eval_idx_reg + SLOT_W'(1);
        end
        else if (cmd.walk_hold)
        begin
            raddr = eval_idx_reg;
        end
        else
        begin
            raddr = '0;
        end
    end

    always_comb
    begin
        a_we    = cmd.exec && (req_reg == REQ_REGISTER) && room;
        a_waddr = count_reg[SLOT_W-1:0];
        a_wdata = {tmo_reg, fat_reg, crit_reg};
        b_we    = 1'b0;
        b_waddr = count_reg[SLOT_W-1:0];
        b_wdata = {now_reg, CL_INIT};
        if (cmd.exec && (req_reg == REQ_REGISTER))
        begin
            b_we = room;
        end
        else if (cmd.exec && (req_reg == REQ_FEED))
        begin
            b_we    = feed_ok;
            b_waddr = idx_reg[SLOT_W-1:0];
            b_wdata = {now_reg, CL_ONLINE};
        end
        else if (report_load)
        begin
            b_we    = 1'b1;
            b_waddr = eval_idx_reg;
            b_wdata = {b_seen, CL_OFFLINE};
        end
    end

    always_comb
    begin
        kind_next  = KIND_ANSWER;
        slot_next  = '0;
        acc_next   = 1'b0;
        fatal_next = 1'b0;
        feed_next  = 1'b0;
        last_next  = 1'b1;
        if (cmd.exec)
        begin
            unique case (req_reg)
                REQ_REGISTER:
                begin
                    slot_next = room ? count_wide[3:0] : 4'd0;
                    acc_next  = room;
                end
                REQ_FEED:
                begin
                    kind_next = KIND_FEED;
                    slot_next = idx_reg;
                    acc_next  = feed_ok;
                end
                REQ_CLEAR:
                begin
                    acc_next = 1'b1;
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
        else if (report_load)
        begin
            kind_next  = KIND_OFFLINE;
            slot_next  = eval_wide[3:0];
            fatal_next = a_fat && fault_hook_en_reg;
            last_next  = 1'b0;
        end
        else
        begin
            kind_next = KIND_TICK_DONE;
            feed_next = hw_feed_en_reg && crit_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            idx_reg  <= client_index;
            now_reg  <= now_ms;
            tmo_reg  <= expiry_ms;
            fat_reg  <= is_fatal;
            crit_reg <= is_critical;
        end
        if (load)
        begin
            kind_reg  <= kind_next;
            slot_reg  <= slot_next;
            acc_reg   <= acc_next;
            fatal_reg <= fatal_next;
            feed_reg  <= feed_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            eval_idx_reg      <= '0;
            crit_ok_reg       <= 1'b1;
            fault_hook_en_reg <= 1'b0;
            hw_feed_en_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_FAULT_HOOK))
            begin
                fault_hook_en_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_HW_FEED))
            begin
                hw_feed_en_reg <= cfg_data;
            end
            if (cmd.exec && (req_reg == REQ_REGISTER) && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.exec && (req_reg == REQ_CLEAR))
            begin
                count_reg <= '0;
            end
            if (cmd.walk_start)
            begin
                eval_idx_reg <= '0;
                crit_ok_reg  <= 1'b1;
            end
            else if (cmd.walk_step)
            begin
                eval_idx_reg <= eval_idx_reg + SLOT_W'(1);
                if (a_crit && !online_after)
                begin
                    crit_ok_reg <= 1'b0;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.req_tick    = req_reg == REQ_TICK;
        stat.out_free    = out_free;
        stat.count_zero  = count_reg == '0;
        stat.last_slot   = (CNT_W'(eval_idx_reg) + CNT_W'(1)) == count_reg;
        stat.need_report = need_report;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = kind_reg;
    assign slot             = slot_reg;
    assign accepted         = acc_reg;
    assign fatal_hook       = fatal_reg;
    assign feed_hw_watchdog = feed_reg;
    assign last             = last_reg;

endmodule

`default_nettype wire

[rtl/core/multi_client_heartbeat_watchdog_unit.sv]
// Register, feed and clear requests: the input beat is captured, then the result
// is registered once the output is free; the next beat is taken after that.
// Tick: walks the N registered clients with one client table read per cycle
// unless an offline report stalls; offline reports leave in slot order.
// Reset clears the client count, both enables and the output valid;
// the client table holds no reset value.
`timescale 1ns / 1ps
`default_nettype none

module multi_client_heartbeat_watchdog_unit #(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // client_index[3:0], now_ms[35:4], expiry_ms[67:36], is_fatal[68],
    // is_critical[69], zero pad[71:70]
    input  wire logic [mchw_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // slot[3:0], accepted[4], fatal_hook[5], feed_hw_watchdog[6], zero pad[7]
    output logic [mchw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    import mchw_pkg::*;

    cmd_t       cmd;
    stat_t      stat;
    logic [3:0] slot;
    logic       accepted;
    logic       fatal_hook;
    logic       feed_hw_watchdog;

    mchw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mchw_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (s_axis_tuser),
        .client_index     (s_axis_tdata[3:0]),
        .now_ms           (s_axis_tdata[35:4]),
        .expiry_ms        (s_axis_tdata[67:36]),
        .is_fatal         (s_axis_tdata[68]),
        .is_critical      (s_axis_tdata[69]),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .result_kind      (m_axis_tuser),
        .slot             (slot),
        .accepted         (accepted),
        .fatal_hook       (fatal_hook),
        .feed_hw_watchdog (feed_hw_watchdog),
        .last             (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, feed_hw_watchdog, fatal_hook, accepted, slot};

endmodule

`default_nettype wire

[rtl/core/mchw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mchw_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    import mchw_pkg::*;

    // hold the result beat while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // only offline reports leave the run open
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_OFFLINE)))
        else $error("tlast does not match result kind");

    // offline report carries no accept and no feed flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_OFFLINE) |->
            !m_axis_tdata[4] && !m_axis_tdata[6])
        else $error("offline report with stray flags");

    // drop ready after taking an input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

endmodule

bind multi_client_heartbeat_watchdog_unit mchw_checker u_mchw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
